// File: hdl/mad_pkg.sv
package mad_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FACTOR_W   = 9;
    localparam int CHAN_CNT_W = 7;
    localparam int BLOCK_W    = 13;
    localparam int POS_W      = 12;
    localparam int MAX_BLOCK  = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BLOCK_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_ABS,
        DIV_RUN,
        DIV_FIN,
        DIV_HOLD
    } div_state_t;

endpackage

// File: hdl/mad_ram.sv
module mad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/mad_div.sv
module mad_div #(
    parameter int SUM_W = 32,
    parameter int DIV_W = 9,
    parameter int OUT_W = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0]        divisor,
    output logic                    busy,
    output logic                    res_valid,
    input  logic                    res_take,
    output logic signed [OUT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (OUT_W - 1);

    mad_pkg::div_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [OUT_W-1:0] res_reg, res_next;
    logic [DIV_W:0]   shifted;
    logic             ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mad_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        res_next   = res_reg;
        shifted    = {rem_reg, quo_reg[SUM_W-1]};
        ge         = (shifted >= {1'b0, dvs_reg});
        unique case (state_reg)
            mad_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[SUM_W-1];
                    quo_next   = dividend;
                    dvs_next   = divisor;
                    state_next = mad_pkg::DIV_ABS;
                end
            end
            mad_pkg::DIV_ABS:
            begin
                quo_next   = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
                rem_next   = '0;
                cnt_next   = CNT_W'(SUM_W - 1);
                state_next = mad_pkg::DIV_RUN;
            end
            mad_pkg::DIV_RUN:
            begin
                rem_next = ge ? DIV_W'(shifted - {1'b0, dvs_reg}) : DIV_W'(shifted);
                quo_next = {quo_reg[SUM_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = mad_pkg::DIV_FIN;
                end
            end
            mad_pkg::DIV_FIN:
            begin
                // saturate magnitude to the signed sample range
                if (neg_reg)
                begin
                    res_next = (quo_reg > HALF) ? OUT_W'(HALF)
                                                : OUT_W'(~quo_reg + SUM_W'(1));
                end
                else
                begin
                    res_next = (quo_reg >= HALF) ? OUT_W'(HALF - SUM_W'(1))
                                                 : OUT_W'(quo_reg);
                end
                state_next = mad_pkg::DIV_HOLD;
            end
            mad_pkg::DIV_HOLD:
            begin
                if (res_take)
                begin
                    state_next = mad_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = mad_pkg::DIV_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != mad_pkg::DIV_IDLE);
    assign res_valid = (state_reg == mad_pkg::DIV_HOLD);
    assign quotient  = res_reg;

endmodule

// File: hdl/multichannel_average_decimator.sv
// an item that closes a group has its channel sum passed to the one-bit-per-cycle restoring
// divider, which takes the magnitude, divides, saturates and hands its result to the output register
// throughput: one item per cycle while no group closes; an item that closes a group
// holds off the next item until the divider hands its result to the output register
// reset: counters cleared, registers at factor 2, one channel, block length 1;
// the sum memory is not cleared, the first sample of each group overwrites its entry
module multichannel_average_decimator #(
    parameter int MAX_CHANNELS = 64,
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_FACTOR   = 256
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_we,
    input  logic [mad_pkg::CFG_IDX_W-1:0]                  cfg_index,
    input  logic [mad_pkg::CFG_DATA_W-1:0]                 cfg_data,
    input  logic                                           in_valid,
    output logic                                           in_stall,
    input  logic signed [SAMPLE_BITS-1:0]                  sample_value,
    input  logic                                           restart,
    output logic                                           out_valid,
    input  logic                                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]                  average_value,
    output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] channel_index,
    output logic                                           block_last
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHL_W = $clog2(MAX_CHANNELS + 1);
    localparam int PH_W  = $clog2(MAX_FACTOR);
    localparam int FCL_W = $clog2(MAX_FACTOR + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_FACTOR);
    localparam int POS_W = mad_pkg::POS_W;
    localparam int BLK_W = mad_pkg::BLOCK_W;

    logic [mad_pkg::FACTOR_W-1:0]   fac_reg;
    logic [mad_pkg::CHAN_CNT_W-1:0] chn_reg;
    logic [BLK_W-1:0]               blk_reg;

    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [FCL_W-1:0] factor;
    logic [CHL_W-1:0] chans;
    logic [BLK_W-1:0] blen;

    logic             acc;
    logic [CH_W-1:0]  ch_eff;
    logic [PH_W-1:0]  phase_eff;
    logic [POS_W-1:0] pos_eff;
    logic             last_ch, group_end, pos_end;

    logic                    s1_valid_reg;
    logic [CH_W-1:0]         s1_ch_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                    s1_first_reg, s1_end_reg, s1_blast_reg;
    logic                    fwd_reg;
    logic signed [SUM_W-1:0] fwd_sum_reg;
    logic signed [SUM_W-1:0] rdata, base, sum1;

    logic [CH_W-1:0] tag_ch_reg;
    logic            tag_last_reg;

    logic                          div_busy, div_res_valid, div_take, div_start;
    logic signed [SAMPLE_BITS-1:0] div_quotient;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg;
    logic [CH_W-1:0]               out_ch_reg;
    logic                          out_last_reg;

    // register clamping
    always_comb
    begin
        if (fac_reg < mad_pkg::FACTOR_W'(2))
        begin
            factor = FCL_W'(2);
        end
        else if (32'(fac_reg) > MAX_FACTOR)
        begin
            factor = FCL_W'(MAX_FACTOR);
        end
        else
        begin
            factor = FCL_W'(fac_reg);
        end

        if (chn_reg == '0)
        begin
            chans = CHL_W'(1);
        end
        else if (32'(chn_reg) > MAX_CHANNELS)
        begin
            chans = CHL_W'(MAX_CHANNELS);
        end
        else
        begin
            chans = CHL_W'(chn_reg);
        end

        if (blk_reg == '0)
        begin
            blen = BLK_W'(1);
        end
        else if (32'(blk_reg) > mad_pkg::MAX_BLOCK)
        begin
            blen = BLK_W'(mad_pkg::MAX_BLOCK);
        end
        else
        begin
            blen = blk_reg;
        end
    end

    assign in_stall = div_busy | (s1_valid_reg & s1_end_reg);
    assign acc      = in_valid & ~in_stall;

    assign ch_eff    = restart ? '0 : ch_reg;
    assign phase_eff = restart ? '0 : phase_reg;
    assign pos_eff   = restart ? '0 : pos_reg;

    assign last_ch   = (CHL_W'(ch_eff) >= chans - CHL_W'(1));
    assign group_end = (FCL_W'(phase_eff) >= factor - FCL_W'(1));
    assign pos_end   = (BLK_W'(pos_eff) >= blen - BLK_W'(1));

    // counter update per accepted item
    always_comb
    begin
        ch_next    = ch_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (acc)
        begin
            ch_next    = last_ch ? '0 : ch_eff + CH_W'(1);
            phase_next = phase_eff;
            pos_next   = pos_eff;
            if (last_ch)
            begin
                if (group_end)
                begin
                    phase_next = '0;
                    pos_next   = pos_end ? '0 : pos_eff + POS_W'(1);
                end
                else
                begin
                    phase_next = phase_eff + PH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fac_reg       <= mad_pkg::FACTOR_W'(2);
            chn_reg       <= mad_pkg::CHAN_CNT_W'(1);
            blk_reg       <= BLK_W'(1);
            ch_reg        <= '0;
            phase_reg     <= '0;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mad_pkg::CFG_DECIMATION_FACTOR:
                        fac_reg <= cfg_data[mad_pkg::FACTOR_W-1:0];
                    mad_pkg::CFG_CHANNEL_COUNT:
                        chn_reg <= cfg_data[mad_pkg::CHAN_CNT_W-1:0];
                    mad_pkg::CFG_OUTPUT_BLOCK_LENGTH:
                        blk_reg <= cfg_data[BLK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            ch_reg        <= ch_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            s1_valid_reg  <= acc;
            fwd_reg       <= acc & s1_valid_reg & (s1_ch_reg == ch_eff);
            out_valid_reg <= div_take | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ch_reg     <= ch_eff;
            s1_sample_reg <= sample_value;
            s1_first_reg  <= (phase_eff == '0);
            s1_end_reg    <= group_end;
            s1_blast_reg  <= last_ch & pos_end;
        end
        fwd_sum_reg <= sum1;
        if (div_start)
        begin
            tag_ch_reg   <= s1_ch_reg;
            tag_last_reg <= s1_blast_reg;
        end
        if (div_take)
        begin
            out_avg_reg  <= div_quotient;
            out_ch_reg   <= tag_ch_reg;
            out_last_reg <= tag_last_reg;
        end
    end

    // read-modify-write of the channel sum, forwarded when back to back on one entry
    assign base = fwd_reg ? fwd_sum_reg : rdata;
    assign sum1 = s1_first_reg ? SUM_W'(s1_sample_reg) : base + SUM_W'(s1_sample_reg);

    mad_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_CHANNELS)
    ) u_sums (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_ch_reg),
        .wdata (sum1),
        .re    (acc),
        .raddr (ch_eff),
        .rdata (rdata)
    );

    assign div_start = s1_valid_reg & s1_end_reg;
    assign div_take  = div_res_valid & (~out_valid_reg | ~out_stall);

    mad_div #(
        .SUM_W (SUM_W),
        .DIV_W (FCL_W),
        .OUT_W (SAMPLE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sum1),
        .divisor   (factor),
        .busy      (div_busy),
        .res_valid (div_res_valid),
        .res_take  (div_take),
        .quotient  (div_quotient)
    );

    assign out_valid     = out_valid_reg;
    assign average_value = out_avg_reg;
    assign channel_index = out_ch_reg;
    assign block_last    = out_last_reg;

endmodule

// File: test/multichannel_average_decimator_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic signed [23:0] avg;
    logic [5:0]         chan;
    logic               last;
} average_result_t;

class average_tracker;
    localparam longint SAMPLE_HI = 64'sd8388607;
    localparam longint SAMPLE_LO = -64'sd8388608;

    logic [8:0]      factor_reg;
    logic [6:0]      chans_reg;
    logic [12:0]     blen_reg;
    longint          channel_total[64];
    bit              seen[64];
    int unsigned     cur_chan;
    int unsigned     phase;
    int unsigned     position;
    average_result_t pending_averages[$];
    int unsigned     failures;

    function new();
        factor_reg = 9'd2;
        chans_reg  = 7'd1;
        blen_reg   = 13'd1;
        cur_chan   = 0;
        phase      = 0;
        position   = 0;
        failures   = 0;
        foreach (channel_total[i])
        begin
            channel_total[i] = 0;
            seen[i]          = 1'b0;
        end
    endfunction

    function void write_reg(logic [mad_pkg::CFG_IDX_W-1:0] idx,
                            logic [mad_pkg::CFG_DATA_W-1:0] data);
        unique case (idx)
            mad_pkg::CFG_DECIMATION_FACTOR:   factor_reg = data[8:0];
            mad_pkg::CFG_CHANNEL_COUNT:       chans_reg  = data[6:0];
            mad_pkg::CFG_OUTPUT_BLOCK_LENGTH: blen_reg   = data[12:0];
            default: ;
        endcase
    endfunction

    // true when this item would add to a sum the block never stored
    function bit blank_read(bit rs);
        if (rs)
            return 1'b0;
        return phase != 0 && !seen[cur_chan];
    endfunction

    function int unsigned pending();
        return pending_averages.size();
    endfunction

    function void take_sample(logic signed [23:0] smp, bit rs);
        longint          factor;
        longint          chans;
        longint          blen;
        longint          avg;
        int unsigned     ch;
        bit              last_ch;
        bit              group_end;
        average_result_t res;

        factor = longint'(factor_reg);
        if (factor < 2)
            factor = 2;
        else if (factor > 256)
            factor = 256;
        chans = longint'(chans_reg);
        if (chans < 1)
            chans = 1;
        else if (chans > 64)
            chans = 64;
        blen = longint'(blen_reg);
        if (blen < 1)
            blen = 1;
        else if (blen > mad_pkg::MAX_BLOCK)
            blen = mad_pkg::MAX_BLOCK;

        if (rs)
        begin
            cur_chan = 0;
            phase    = 0;
            position = 0;
        end
        ch        = cur_chan % 64;
        last_ch   = ch >= chans - 1;
        group_end = phase >= factor - 1;

        if (phase == 0)
            channel_total[ch] = longint'(smp);
        else
            channel_total[ch] += longint'(smp);
        seen[ch] = 1'b1;

        if (group_end)
        begin
            avg = channel_total[ch] / factor;
            if (avg > SAMPLE_HI)
                avg = SAMPLE_HI;
            if (avg < SAMPLE_LO)
                avg = SAMPLE_LO;
            res.avg  = avg[23:0];
            res.chan = ch[5:0];
            res.last = last_ch && position >= blen - 1;
            pending_averages.push_back(res);
        end

        if (last_ch)
        begin
            cur_chan = 0;
            if (group_end)
            begin
                phase = 0;
                if (position >= blen - 1)
                    position = 0;
                else
                    position++;
            end
            else
            begin
                phase++;
            end
        end
        else
        begin
            cur_chan = ch + 1;
        end
    endfunction

    function void compare_average(logic signed [23:0] avg, logic [5:0] chan, logic last);
        average_result_t want;

        if (pending_averages.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected average %0d ch %0d last %0b",
                         $signed(avg), chan, last);
            return;
        end
        want = pending_averages.pop_front();
        if (want.avg !== avg || want.chan !== chan || want.last !== last)
        begin
            failures++;
            if (failures <= 10)
                $display("average mismatch: expected %0d ch %0d last %0b, %s %0d ch %0d last %0b",
                         $signed(want.avg), want.chan, want.last, "got",
                         $signed(avg), chan, last);
        end
    endfunction
endclass

module multichannel_average_decimator_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 1400;

    localparam logic [mad_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic signed [23:0]            SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0]            SAMPLE_MIN = 24'sh800000;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_we       = 1'b0;
    logic [mad_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [mad_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic signed [23:0]              sample_value = '0;
    logic                            restart      = 1'b0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic signed [23:0]              average_value;
    logic [5:0]                      channel_index;
    logic                            block_last;

    int unsigned    gap_pct     = 0;
    int unsigned    stall_pct   = 0;
    int unsigned    cycle_count = 0;
    average_tracker tracker;

    multichannel_average_decimator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_value  (sample_value),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average_value (average_value),
        .channel_index (channel_index),
        .block_last    (block_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_average(average_value, channel_index, block_last);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [23:0] pick_sample();
        unique case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 24'(int'($urandom_range(0, 15)) - 8);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic set_idling(input int unsigned mode);
        unique case (mode)
            0:
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1:
            begin
                gap_pct   = 58;
                stall_pct = 0;
            end
            2:
            begin
                gap_pct   = 0;
                stall_pct = 58;
            end
            default:
            begin
                gap_pct   = 28;
                stall_pct = 28;
            end
        endcase
    endtask

    task automatic write_register(input logic [mad_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mad_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic push_item(input logic signed [23:0] smp, input bit rs);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        if (tracker.blank_read(rs))
            rs = 1'b1;
        in_valid     <= 1'b1;
        sample_value <= smp;
        restart      <= rs;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_sample(smp, rs);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned                    random_items;
        int unsigned                    phase_no;
        int unsigned                    kind;
        int unsigned                    n;
        logic [mad_pkg::CFG_DATA_W-1:0] f;
        logic [mad_pkg::CFG_DATA_W-1:0] c;
        logic [mad_pkg::CFG_DATA_W-1:0] b;

        tracker = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register values after reset: factor two, one channel, every average ends a block
        set_idling(0);
        push_item(SAMPLE_MAX, 1'b0);
        push_item(SAMPLE_MAX, 1'b0);
        push_item(SAMPLE_MIN, 1'b0);
        push_item(SAMPLE_MIN, 1'b0);
        push_item(-24'sd1, 1'b0);
        push_item(24'sd0, 1'b0);
        push_item(24'sd5, 1'b0);
        push_item(24'sd7, 1'b1);
        push_item(24'sd9, 1'b0);
        wait_drained();

        // factor cut mid-group drives the average past the sample range
        write_register(CFG_SPARE, mad_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
        write_register(mad_pkg::CFG_DECIMATION_FACTOR, 13'd8);
        repeat (7) push_item(SAMPLE_MAX, 1'b0);
        wait_drained();
        write_register(mad_pkg::CFG_DECIMATION_FACTOR, 13'd2);
        push_item(SAMPLE_MAX, 1'b0);
        wait_drained();
        write_register(mad_pkg::CFG_DECIMATION_FACTOR, 13'd8);
        repeat (7) push_item(SAMPLE_MIN, 1'b0);
        wait_drained();
        write_register(mad_pkg::CFG_DECIMATION_FACTOR, 13'd2);
        push_item(SAMPLE_MIN, 1'b0);
        wait_drained();

        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            set_idling(phase_no % 4);
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                f = mad_pkg::CFG_DATA_W'($urandom_range(2, 6));
                c = mad_pkg::CFG_DATA_W'($urandom_range(1, 8));
                b = mad_pkg::CFG_DATA_W'(($urandom_range(0, 7) == 0) ? mad_pkg::MAX_BLOCK
                                                                     : $urandom_range(1, 6));
                n = $urandom_range(20, 120);
            end
            else if (kind < 8)
            begin
                f = mad_pkg::CFG_DATA_W'($urandom_range(2, 3));
                c = mad_pkg::CFG_DATA_W'($urandom_range(0, 1) ? 64 : $urandom_range(9, 63));
                b = mad_pkg::CFG_DATA_W'($urandom_range(1, 3));
                n = f * c * $urandom_range(1, 2) + $urandom_range(0, 10);
            end
            else if (kind == 8)
            begin
                f = mad_pkg::CFG_DATA_W'($urandom_range(0, 1) ? 256 : $urandom_range(100, 255));
                c = mad_pkg::CFG_DATA_W'(1);
                b = mad_pkg::CFG_DATA_W'($urandom_range(0, 1) ? mad_pkg::MAX_BLOCK
                                                             : $urandom_range(1, 3));
                n = 300;
            end
            else
            begin
                f = mad_pkg::CFG_DATA_W'($urandom_range(0, 1)
                        ? $urandom_range(0, 1)
                        : ($urandom_range(1, 15) << 9) | $urandom_range(0, 8));
                c = mad_pkg::CFG_DATA_W'($urandom_range(0, 1)
                        ? ($urandom_range(0, 1) ? 0 : $urandom_range(65, 127))
                        : ($urandom_range(1, 63) << 7) | $urandom_range(0, 6));
                b = mad_pkg::CFG_DATA_W'($urandom_range(0, 8191));
                n = 150;
            end

            write_register(mad_pkg::CFG_DECIMATION_FACTOR, f);
            write_register(mad_pkg::CFG_CHANNEL_COUNT, c);
            write_register(mad_pkg::CFG_OUTPUT_BLOCK_LENGTH, b);
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_SPARE, mad_pkg::CFG_DATA_W'($urandom_range(0, 8191)));

            push_item(pick_sample(), $urandom_range(0, 9) < 3);
            repeat (n - 1) push_item(pick_sample(), $urandom_range(0, 99) < 3);
            random_items += n;
            wait_drained();
            phase_no++;
        end

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: filelist.f
hdl/mad_pkg.sv
hdl/mad_ram.sv
hdl/mad_div.sv
hdl/multichannel_average_decimator.sv
test/multichannel_average_decimator_tb.sv
